### rtl/ukdf_pkg.sv
// ----------------------------------------------------------------------------
// ukdf_pkg
// Shared constants and controller/datapath signal groups for the duplicate
// key filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ukdf_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int HALF_W      = 16;
   localparam int KEY_W       = 2 * HALF_W;

   localparam logic ACT_CHECK = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   typedef struct packed {
      logic load;     // capture an accepted beat
      logic scan;     // walk the occupied slots
      logic finish;   // commit and load the result register
   } ukdf_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } ukdf_status_type;

endpackage

`default_nettype wire

### rtl/ukdf_if.sv
// ----------------------------------------------------------------------------
// ukdf_if
// Valid/ready channels for the filter's request and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ukdf_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] category_id;
   logic [15:0] item_id;

   modport source (output valid, action, category_id, item_id, input ready);
   modport sink   (input valid, action, category_id, item_id, output ready);
endinterface

interface ukdf_rsp_if;
   logic valid;
   logic ready;
   logic is_new;
   logic was_stored;
   logic table_full;

   modport source (output valid, is_new, was_stored, table_full, input ready);
   modport sink   (input valid, is_new, was_stored, table_full, output ready);
endinterface

`default_nettype wire

### rtl/ukdf_ctrl.sv
// ----------------------------------------------------------------------------
// ukdf_ctrl
// Sequencer: takes a request beat, runs the table scan, then commits the
// result once the response register can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module ukdf_ctrl
   import ukdf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire ukdf_status_type status,
   output      ukdf_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_RESULT = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ukdf_dpath.sv
// ----------------------------------------------------------------------------
// ukdf_dpath
// Key register, seen-key memory with fill count, scan compare and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ukdf_dpath
   import ukdf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ukdf_cmd_type       cmd,
   output      ukdf_status_type    status,
   input  wire logic               req_action,
   input  wire logic [HALF_W-1:0]  req_category_id,
   input  wire logic [HALF_W-1:0]  req_item_id,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic               rsp_is_new,
   output      logic               rsp_was_stored,
   output      logic               rsp_table_full
);

   logic [KEY_W-1:0] mem [TABLE_DEPTH];

   logic             action_ff;
   logic [KEY_W-1:0] key_ff;
   logic [CNT_W-1:0] used_count_ff;
   logic [CNT_W-1:0] used_count_in;
   logic [CNT_W-1:0] idx_ff;
   logic [KEY_W-1:0] rd_data_ff;
   logic             rd_pend_ff;
   logic             hit_ff;
   logic             rsp_valid_ff;
   logic             is_new_ff;
   logic             was_stored_ff;
   logic             table_full_ff;

   logic skip;
   logic issue;
   logic has_room;
   logic do_store;
   logic match;

   assign skip     = (action_ff == ACT_CLEAR) || (key_ff == '0);
   assign issue    = cmd.scan && !skip && !hit_ff && (idx_ff != used_count_ff);
   assign match    = rd_pend_ff && (rd_data_ff == key_ff);
   assign has_room = used_count_ff < CNT_W'(TABLE_DEPTH);
   assign do_store = cmd.finish && !skip && !hit_ff && has_room;

   assign status.scan_done = !rd_pend_ff && (skip || hit_ff || (idx_ff == used_count_ff));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // clear only drops the fill count; slots past it are never read
   always_comb begin
      used_count_in = used_count_ff;
      if (cmd.finish && (action_ff == ACT_CLEAR)) begin
         used_count_in = '0;
      end else if (do_store) begin
         used_count_in = used_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         mem[used_count_ff[ADDR_W-1:0]] <= key_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[idx_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         key_ff    <= {req_category_id, req_item_id};
      end
      if (cmd.finish) begin
         is_new_ff     <= (action_ff != ACT_CLEAR) && ((key_ff == '0) || !hit_ff);
         was_stored_ff <= do_store;
         table_full_ff <= !skip && !hit_ff && !has_room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
         idx_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_count_ff <= used_count_in;
         rd_pend_ff    <= issue;
         if (cmd.load) begin
            idx_ff <= '0;
            hit_ff <= 1'b0;
         end else begin
            if (issue) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
            if (match) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_new     = is_new_ff;
   assign rsp_was_stored = was_stored_ff;
   assign rsp_table_full = table_full_ff;

endmodule

`default_nettype wire

### rtl/unique_key_dedup_filter.sv
// Timing: a check reads the occupied slots in order and compares each read-back key; a hit
//   ends the scan early, and a clear, a zero key or an empty table skips it.
// Throughput: one beat in flight; the scan reads one slot per cycle, and the next beat is
//   accepted only after the result of the last one has been committed to the response register.
// Reset: synchronous, empties the table (fill count to zero), no clearing pass.
// ----------------------------------------------------------------------------
// unique_key_dedup_filter
// Flags each category/item key as new until it is stored (a zero key always is); keeps the
// seen keys in an append-only table with a clear action.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_key_dedup_filter
   import ukdf_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ukdf_req_if.sink    req,
   ukdf_rsp_if.source  rsp
);

   ukdf_cmd_type    cmd;
   ukdf_status_type status;

   ukdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ukdf_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req.action),
      .req_category_id (req.category_id),
      .req_item_id     (req.item_id),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_is_new      (rsp.is_new),
      .rsp_was_stored  (rsp.was_stored),
      .rsp_table_full  (rsp.table_full)
   );

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the duplicate key filter. A driver sends check and
// clear beats from a queue built up front, a monitor compares every response
// with a behavioral table model, and both sides idle in several patterns.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ukdf_pkg::*;

   typedef struct packed {
      logic              action;
      logic [HALF_W-1:0] category_id;
      logic [HALF_W-1:0] item_id;
   } filter_beat_type;

   typedef struct packed {
      logic is_new;
      logic was_stored;
      logic table_full;
   } verdict_type;

   logic clock;
   logic reset;

   ukdf_req_if req_ch ();
   ukdf_rsp_if rsp_ch ();

   unique_key_dedup_filter u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   filter_beat_type beat_q[$];
   verdict_type     verdict_q[$];
   filter_beat_type cur_beat;

   // shadow of the seen-key table
   logic [KEY_W-1:0] seen_tbl [TABLE_DEPTH];
   int unsigned      seen_cnt;

   int unsigned tx_idle_pct;
   int unsigned rx_stall_pct;
   bit          hold_tx;

   int unsigned accepted_cnt;
   int unsigned rsp_cnt;
   int unsigned mismatch_cnt;
   int unsigned n_stored, n_dup, n_full, n_clear, n_zero;

   task automatic report_mismatch(input string what);
      mismatch_cnt++;
      if (mismatch_cnt <= 100) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   function automatic verdict_type predict_verdict(input filter_beat_type b);
      verdict_type      v;
      logic [KEY_W-1:0] key;
      bit               hit;
      v   = '0;
      key = {b.category_id, b.item_id};
      hit = 0;
      if (b.action == ACT_CLEAR) begin
         seen_cnt = 0;
         foreach (seen_tbl[i]) seen_tbl[i] = '0;
         n_clear++;
         return v;
      end
      if (key == '0) begin
         v.is_new = 1'b1;
         n_zero++;
         return v;
      end
      for (int i = 0; i < seen_cnt; i++) begin
         if (seen_tbl[i] == key) hit = 1;
      end
      if (hit) begin
         n_dup++;
         return v;
      end
      v.is_new = 1'b1;
      if (seen_cnt < TABLE_DEPTH) begin
         seen_tbl[seen_cnt] = key;
         seen_cnt++;
         v.was_stored = 1'b1;
         n_stored++;
      end else begin
         v.table_full = 1'b1;
         n_full++;
      end
      return v;
   endfunction

   function automatic void add_beat(input logic act, input logic [HALF_W-1:0] cat,
                                    input logic [HALF_W-1:0] itm);
      filter_beat_type b;
      b.action      = act;
      b.category_id = cat;
      b.item_id     = itm;
      beat_q.push_back(b);
   endfunction

   function automatic void add_check_key(input logic [KEY_W-1:0] key);
      add_beat(ACT_CHECK, key[KEY_W-1:HALF_W], key[HALF_W-1:0]);
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      return {16'($urandom), 16'($urandom)};
   endfunction

   // clock, reset and known input levels from time zero
   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_CHECK;
      req_ch.category_id  = '0;
      req_ch.item_id      = '0;
      rsp_ch.ready        = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #8ms;
      $display("tb NOT OK");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            verdict_q.push_back(predict_verdict(cur_beat));
            accepted_cnt++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (beat_q.size() > 0 && !hold_tx && $urandom_range(0, 99) >= tx_idle_pct) begin
               cur_beat            = beat_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.action      <= cur_beat.action;
               req_ch.category_id <= cur_beat.category_id;
               req_ch.item_id     <= cur_beat.item_id;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      verdict_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_cnt++;
            got = {rsp_ch.is_new, rsp_ch.was_stored, rsp_ch.table_full};
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("response %0d with no beat outstanding", rsp_cnt));
            end else begin
               want = verdict_q.pop_front();
               if (got.is_new !== want.is_new)
                  report_mismatch($sformatf("response %0d is_new %b, want %b",
                                            rsp_cnt, got.is_new, want.is_new));
               if (got.was_stored !== want.was_stored)
                  report_mismatch($sformatf("response %0d was_stored %b, want %b",
                                            rsp_cnt, got.was_stored, want.was_stored));
               if (got.table_full !== want.table_full)
                  report_mismatch($sformatf("response %0d table_full %b, want %b",
                                            rsp_cnt, got.table_full, want.table_full));
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // stimulus and run control
   initial begin
      logic [KEY_W-1:0] key_pool[$];
      int unsigned      pool_n, seq_len, r, next_switch, mode;
      int unsigned      total_beats;
      bit               paused;

      seen_cnt     = 0;
      foreach (seen_tbl[i]) seen_tbl[i] = '0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_tx      = 0;

      // directed: zero key, extreme halves, sign bit of item id, clears
      add_beat(ACT_CHECK, 16'h0000, 16'h0000);
      add_beat(ACT_CHECK, 16'h0000, 16'h0000);
      add_beat(ACT_CHECK, 16'hFFFF, 16'hFFFF);
      add_beat(ACT_CHECK, 16'hFFFF, 16'hFFFF);
      add_beat(ACT_CHECK, 16'h0000, 16'hFFFF);
      add_beat(ACT_CHECK, 16'hFFFF, 16'h0000);
      add_beat(ACT_CHECK, 16'h0001, 16'h8000);
      add_beat(ACT_CHECK, 16'h0001, 16'hFFFF);
      add_beat(ACT_CHECK, 16'h0001, 16'h8000);
      add_beat(ACT_CHECK, 16'h0000, 16'h0001);
      add_beat(ACT_CHECK, 16'h8000, 16'h0000);
      add_beat(ACT_CHECK, 16'h0000, 16'hFFFF);
      add_beat(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
      add_beat(ACT_CHECK, 16'hFFFF, 16'hFFFF);
      add_beat(ACT_CHECK, 16'h0000, 16'hFFFF);
      add_beat(ACT_CLEAR, 16'h0000, 16'h0000);
      add_beat(ACT_CLEAR, 16'h0000, 16'h0000);
      add_beat(ACT_CHECK, 16'h5A5A, 16'hA5A5);
      add_beat(ACT_CHECK, 16'hA5A5, 16'h5A5A);
      add_beat(ACT_CHECK, 16'h5A5A, 16'hA5A5);
      add_beat(ACT_CHECK, 16'h0000, 16'h0000);

      // random: mostly clear-then-fill runs over a key pool, some noise
      while (beat_q.size() < 1050) begin
         if ($urandom_range(0, 99) < 75) begin
            key_pool.delete();
            pool_n = $urandom_range(60, 90);
            for (int i = 0; i < pool_n; i++) key_pool.push_back(random_key());
            add_beat(ACT_CLEAR, 16'($urandom), 16'($urandom));
            seq_len = $urandom_range(60, 130);
            for (int i = 0; i < seq_len; i++) begin
               r = $urandom_range(0, 99);
               if (r < 80)
                  add_check_key(key_pool[$urandom_range(0, pool_n - 1)]);
               else if (r < 90)
                  add_check_key(random_key());
               else if (r < 95)
                  add_check_key('0);
               else
                  add_check_key(key_pool[0]);
            end
         end else begin
            seq_len = $urandom_range(5, 20);
            for (int i = 0; i < seq_len; i++)
               add_beat(($urandom_range(0, 9) == 0) ? ACT_CLEAR : ACT_CHECK,
                        16'($urandom), 16'($urandom));
         end
      end
      while (beat_q.size() > 1050) void'(beat_q.pop_back());
      total_beats = beat_q.size();

      // idling pattern rotates every 90 accepted beats
      next_switch = 90;
      mode        = 0;
      paused      = 0;
      while (beat_q.size() > 0) begin
         @(posedge clock);
         if (accepted_cnt >= next_switch) begin
            next_switch += 90;
            mode = (mode + 1) % 4;
            tx_idle_pct  <= (mode == 1) ? 78 : (mode == 3) ? 7 : 0;
            rx_stall_pct <= (mode == 2) ? 78 : (mode == 3) ? 7 : 0;
         end
         if (!paused && accepted_cnt >= 500) begin
            paused = 1;
            hold_tx <= 1'b1;
            @(posedge clock);
            while (req_ch.valid || verdict_q.size() != 0) @(posedge clock);
            hold_tx <= 1'b0;
         end
      end

      while (rsp_cnt < total_beats) @(posedge clock);
      repeat (80) @(posedge clock);

      if (accepted_cnt != total_beats || verdict_q.size() != 0)
         report_mismatch($sformatf("%0d beats accepted of %0d, %0d responses outstanding",
                                   accepted_cnt, total_beats, verdict_q.size()));

      $display("covered %0d beats: %0d keys stored, %0d duplicates, %0d refused on a full table",
               rsp_cnt, n_stored, n_dup, n_full);
      $display("plus %0d clears and %0d zero keys, with four idle patterns and a drain pause",
               n_clear, n_zero);
      if (mismatch_cnt == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
rtl/ukdf_pkg.sv
rtl/ukdf_if.sv
rtl/ukdf_ctrl.sv
rtl/ukdf_dpath.sv
rtl/unique_key_dedup_filter.sv
tb/tb.sv
